// ===== rtl/core/lmrs_pkg.sv =====
// Shared types and constants for the LED matrix row scan core.
// Item and result structs, opcodes, register indexes, FSM states and
// the command/status bundles between controller and datapath.
package lmrs_pkg;

    localparam int MAX_ROW_BYTES = 8;
    localparam int HALF_ROWS     = 16;
    localparam int STORE_BYTES   = 256;

    localparam int ADDR_W = $clog2(STORE_BYTES);
    localparam int COL_W  = 3;
    localparam int ROW_W  = 4;
    localparam int RB_W   = 4;
    localparam int DATA_W = 8;

    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_CLEAR = 2'd1;
    localparam logic [1:0] OP_SCAN  = 2'd2;

    localparam logic [1:0] CFG_ROW_BYTES   = 2'd0;
    localparam logic [1:0] CFG_INVERT_MASK = 2'd1;
    localparam logic [1:0] CFG_DATA_MASK   = 2'd2;

    localparam logic [RB_W-1:0]   ROW_BYTES_RESET   = RB_W'(8);
    localparam logic [DATA_W-1:0] INVERT_MASK_RESET = 8'h00;
    localparam logic [DATA_W-1:0] DATA_MASK_RESET   = 8'hFF;

    typedef struct packed {
        logic [1:0]        op;
        logic [7:0]        address;
        logic [DATA_W-1:0] write_data;
    } item_t;

    typedef struct packed {
        logic [DATA_W-1:0] upper_bits;
        logic [DATA_W-1:0] lower_bits;
        logic [COL_W-1:0]  column_byte;
        logic [ROW_W-1:0]  row_address;
        logic              last_of_row;
    } result_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_READ,
        ST_LOAD
    } state_t;

    typedef struct packed {
        logic mem_write;   // store the accepted write item
        logic scan_start;  // latch row base addresses, reset column
        logic clr_write;   // write zero at the clear pointer
        logic rd_en;       // read the byte pair
        logic rd_ahead;    // read column + 1 instead of column
        logic load_out;    // load result register, advance column
        logic row_advance; // step scan row
    } cmd_t;

    typedef struct packed {
        logic col_last;
        logic clr_last;
        logic out_free;
    } status_t;

endpackage

// ===== rtl/core/lmrs_ctrl.sv =====
// Controller FSM for the LED matrix row scan core.
// Depends on lmrs_pkg for states, opcodes and the cmd/status structs.
module lmrs_ctrl
    import lmrs_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    item_valid,
    input  logic [1:0] item_op,
    output logic    item_stall,
    input  status_t status,
    output cmd_t    cmd
);

    state_t state_reg;
    state_t state_next;
    logic   accept;

    assign item_stall = (state_reg != ST_IDLE);
    assign accept     = item_valid && !item_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (item_op)
                        OP_CLEAR: state_next = ST_CLEAR;
                        OP_SCAN:  state_next = ST_READ;
                        default:  state_next = ST_IDLE;
                    endcase
                end
            end
            ST_CLEAR:
            begin
                if (status.clr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_READ:
            begin
                state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                if (status.out_free && status.col_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd = '0;
        case (state_reg)
            ST_IDLE:
            begin
                cmd.mem_write  = accept && (item_op == OP_WRITE);
                cmd.scan_start = accept && (item_op == OP_SCAN);
            end
            ST_CLEAR:
            begin
                cmd.clr_write = 1'b1;
            end
            ST_READ:
            begin
                cmd.rd_en = 1'b1;
            end
            ST_LOAD:
            begin
                if (status.out_free)
                begin
                    cmd.load_out = 1'b1;
                    if (status.col_last)
                    begin
                        cmd.row_advance = 1'b1;
                    end
                    else
                    begin
                        // prefetch the next byte pair while this one goes out
                        cmd.rd_en    = 1'b1;
                        cmd.rd_ahead = 1'b1;
                    end
                end
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    a_read_then_load: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.rd_en |=> state_reg == ST_LOAD)
        else $error("read issued without load state following");

    a_clear_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) && !status.clr_last |=> state_reg == ST_CLEAR)
        else $error("clear sweep left early");

endmodule

// ===== rtl/core/lmrs_datapath.sv =====
// Datapath for the LED matrix row scan core: frame store memory, config
// registers, scan row and column counters, pixel shaping, result register.
// Depends on lmrs_pkg.
module lmrs_datapath
    import lmrs_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  item_t             item,
    input  logic              cfg_valid,
    input  logic [1:0]        cfg_index,
    input  logic [DATA_W-1:0] cfg_data,
    input  cmd_t              cmd,
    output status_t           status,
    output result_t           result,
    output logic              result_valid,
    input  logic              result_stall
);

    logic [DATA_W-1:0] mem [STORE_BYTES];

    logic [RB_W-1:0]   rb_reg;
    logic [DATA_W-1:0] inv_reg;
    logic [DATA_W-1:0] dmask_reg;
    logic [ROW_W-1:0]  scan_row_reg;
    logic [ROW_W-1:0]  scan_row_next;
    logic [COL_W-1:0]  col_reg;
    logic [ADDR_W-1:0] clr_cnt_reg;
    logic [ADDR_W-1:0] top_base_reg;
    logic [ADDR_W-1:0] bot_base_reg;
    logic [ADDR_W-1:0] top_base_next;
    logic [ADDR_W-1:0] bot_base_next;
    logic [DATA_W-1:0] rd_top_reg;
    logic [DATA_W-1:0] rd_bot_reg;
    logic              result_valid_reg;
    result_t           result_reg;
    result_t           result_next;

    logic [RB_W-1:0]   rb_sat;
    logic [COL_W-1:0]  rd_col;
    logic [ADDR_W-1:0] rd_addr_top;
    logic [ADDR_W-1:0] rd_addr_bot;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_wa;
    logic [DATA_W-1:0] mem_wd;

    // row_bytes saturates into 1..MAX_ROW_BYTES at write time
    always_comb
    begin
        if (cfg_data[RB_W-1:0] == '0)
        begin
            rb_sat = RB_W'(1);
        end
        else if (int'(cfg_data[RB_W-1:0]) > MAX_ROW_BYTES)
        begin
            rb_sat = RB_W'(MAX_ROW_BYTES);
        end
        else
        begin
            rb_sat = cfg_data[RB_W-1:0];
        end
    end

    assign top_base_next = ADDR_W'(int'(scan_row_reg) * int'(rb_reg));
    assign bot_base_next = top_base_next + ADDR_W'(int'(rb_reg) * HALF_ROWS);
    assign scan_row_next = (int'(scan_row_reg) == HALF_ROWS - 1) ? '0
                                                                 : scan_row_reg + 1'b1;

    assign rd_col      = cmd.rd_ahead ? col_reg + 1'b1 : col_reg;
    assign rd_addr_top = top_base_reg + ADDR_W'(rd_col);
    assign rd_addr_bot = bot_base_reg + ADDR_W'(rd_col);

    assign mem_we = cmd.mem_write || cmd.clr_write;
    assign mem_wa = cmd.clr_write ? clr_cnt_reg : item.address[ADDR_W-1:0];
    assign mem_wd = cmd.clr_write ? '0 : item.write_data;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= mem_wd;
        end
        if (cmd.rd_en)
        begin
            rd_top_reg <= mem[rd_addr_top];
            rd_bot_reg <= mem[rd_addr_bot];
        end
    end

    always_comb
    begin
        result_next.upper_bits  = (rd_top_reg ^ inv_reg) & dmask_reg;
        result_next.lower_bits  = (rd_bot_reg ^ inv_reg) & dmask_reg;
        result_next.column_byte = col_reg;
        result_next.row_address = scan_row_reg;
        result_next.last_of_row = status.col_last;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.scan_start)
        begin
            top_base_reg <= top_base_next;
            bot_base_reg <= bot_base_next;
        end
        if (cmd.load_out)
        begin
            result_reg <= result_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rb_reg           <= ROW_BYTES_RESET;
            inv_reg          <= INVERT_MASK_RESET;
            dmask_reg        <= DATA_MASK_RESET;
            scan_row_reg     <= '0;
            col_reg          <= '0;
            clr_cnt_reg      <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                case (cfg_index)
                    CFG_ROW_BYTES:   rb_reg    <= rb_sat;
                    CFG_INVERT_MASK: inv_reg   <= cfg_data;
                    CFG_DATA_MASK:   dmask_reg <= cfg_data;
                    default:         ;
                endcase
            end
            if (cmd.scan_start)
            begin
                col_reg <= '0;
            end
            else if (cmd.load_out)
            begin
                col_reg <= col_reg + 1'b1;
            end
            if (cmd.row_advance)
            begin
                scan_row_reg <= scan_row_next;
            end
            // pointer wraps back to zero at the end of a full sweep
            if (cmd.clr_write)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
            if (cmd.load_out)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    assign status.col_last = (col_reg == COL_W'(rb_reg - 1'b1));
    assign status.clr_last = (clr_cnt_reg == ADDR_W'(STORE_BYTES - 1));
    assign status.out_free = !result_valid_reg || !result_stall;

    assign result       = result_reg;
    assign result_valid = result_valid_reg;

    a_load_only_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!result_valid_reg || !result_stall))
        else $error("result register overwritten while held");

    a_last_flags_result: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out && status.col_last |=> result_reg.last_of_row
            && scan_row_reg != $past(scan_row_reg))
        else $error("row end not flagged or row not advanced");

endmodule

// ===== rtl/core/led_matrix_row_scan_core.sv =====
// LED matrix row scan core, 32-row panel with 1/16 scan.
// Channel usage:
//   item channel (item_valid/item_stall/item): op WRITE stores one frame
//   byte, op CLEAR zeroes the whole frame store, op SCAN emits one result
//   per byte column of the current row, then steps the row (0..15, wraps).
//   result channel (result_valid/result_stall/result): upper/lower half
//   bytes after invert and data masks, column, row select, last_of_row.
//   cfg channel (cfg_valid/cfg_ready/cfg_index/cfg_data): row_bytes,
//   invert_mask, data_mask; always ready, write only while idle.
// Timing: a write never raises item_stall. A clear holds item_stall while it
// zeroes the store, one store entry per cycle. A scan reads a byte pair in
// the read state, then loads results in the load state, one per cycle with
// no result stall, and holds item_stall until the last result of the row.
// Reset: row 0, row_bytes 8, invert_mask 0, data_mask 255; the frame store
// is not cleared and must be written or cleared before it is scanned.
// A result stall on a valid result freezes the result register and the scan sequence.
// Depends on lmrs_pkg, lmrs_ctrl and lmrs_datapath.
module led_matrix_row_scan_core
    import lmrs_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_stall,
    input  item_t             item,
    output logic              result_valid,
    input  logic              result_stall,
    output result_t           result,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [1:0]        cfg_index,
    input  logic [DATA_W-1:0] cfg_data
);

    cmd_t    cmd;
    status_t status;

    assign cfg_ready = 1'b1;

    lmrs_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_op    (item.op),
        .item_stall (item_stall),
        .status     (status),
        .cmd        (cmd)
    );

    lmrs_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item),
        .cfg_valid    (cfg_valid && cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .cmd          (cmd),
        .status       (status),
        .result       (result),
        .result_valid (result_valid),
        .result_stall (result_stall)
    );

endmodule
